// ===== sv/byte_ring_fifo_block_commit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BYTE_RING_FIFO_BLOCK_COMMIT_DEFINES_SVH
`define BYTE_RING_FIFO_BLOCK_COMMIT_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define BRF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define BRF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `BRF_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `BRF_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== sv/brfbc_pkg.sv =====
package brfbc_pkg;

    localparam int DEPTH    = 4096;
    localparam int MAX_READ = 64;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = ADDR_W + 1;
    localparam int CNT_W  = 13;
    localparam int N_W    = $clog2(MAX_READ + 1);
    localparam int CMP_W  = (PTR_W > CNT_W) ? PTR_W : CNT_W;

    // input commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_DRAIN = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_WACK  = 2'd0;
    localparam logic [1:0] KIND_RDATA = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_DRAIN = 2'd3;

    typedef struct packed {
        logic           op_write;
        logic           op_read;
        logic           op_drain;
        logic           op_empty;
        logic           rd_issue;
        logic           rd_load;
        logic           rd_last;
        logic [N_W-1:0] rd_off;
        logic [N_W-1:0] rd_n;
    } t_dp_cmd;

    typedef struct packed {
        logic           out_free;
        logic           rd_empty;
        logic [N_W-1:0] rd_n;
    } t_dp_stat;

endpackage

// ===== sv/brfbc_ctrl.sv =====
module brfbc_ctrl
    import brfbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_in_cmd,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic           r_state, n_state;
    logic [N_W-1:0] r_n, n_n;
    logic [N_W-1:0] r_ki, n_ki;
    logic [N_W-1:0] r_ke, n_ke;
    logic           r_pend, n_pend;
    logic           w_accept;
    logic           w_load;
    logic           w_issue;
    logic           w_last;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // read burst: one outstanding memory read, held until the output takes it
    assign w_load  = (r_state == S_READ) && r_pend && i_stat.out_free;
    assign w_issue = (r_state == S_READ) && (r_ki != r_n) && (!r_pend || w_load);
    assign w_last  = (N_W'(r_ke + N_W'(1)) == r_n);

    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_issue = w_issue;
        o_cmd.rd_load  = w_load;
        o_cmd.rd_last  = w_last;
        o_cmd.rd_off   = r_ki;
        o_cmd.rd_n     = r_n;
        n_state        = r_state;
        n_n            = r_n;
        n_ki           = w_issue ? N_W'(r_ki + N_W'(1)) : r_ki;
        n_ke           = w_load ? N_W'(r_ke + N_W'(1)) : r_ke;
        n_pend         = w_issue ? 1'b1 : (w_load ? 1'b0 : r_pend);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_cmd)
                        CMD_WRITE: o_cmd.op_write = 1'b1;
                        CMD_DRAIN: o_cmd.op_drain = 1'b1;
                        CMD_READ: begin
                            if (i_stat.rd_empty) begin
                                o_cmd.op_empty = 1'b1;
                            end else begin
                                o_cmd.op_read = 1'b1;
                                n_state       = S_READ;
                                n_n           = i_stat.rd_n;
                                n_ki          = '0;
                                n_ke          = '0;
                                n_pend        = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (w_load && w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_ki    <= '0;
            r_ke    <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_ki    <= n_ki;
            r_ke    <= n_ke;
            r_pend  <= n_pend;
        end
    end

endmodule

// ===== sv/brfbc_dp.sv =====
module brfbc_dp
    import brfbc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wen,
    input  logic             i_cfg_wdata,
    input  logic [7:0]       i_data_in,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_first,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_out,
    output logic [CNT_W-1:0] o_done_count,
    output logic             o_last,
    output logic [CNT_W-1:0] o_readable,
    output logic [CNT_W-1:0] o_writable
);

    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_rdata;

    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [PTR_W-1:0] r_sp, n_sp;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic             r_acc, n_acc;
    logic [PTR_W-1:0] r_base, n_base;
    logic             r_hold;

    logic             r_ovalid, n_ovalid;
    logic [1:0]       r_kind;
    logic [7:0]       r_dout;
    logic [CNT_W-1:0] r_done;
    logic             r_last;
    logic [CNT_W-1:0] r_readable;
    logic [CNT_W-1:0] r_writable;

    logic [PTR_W-1:0] w_lvl;
    logic [PTR_W-1:0] w_space;
    logic [PTR_W-1:0] w_lvl_next;
    logic             w_acc_ok;
    logic [PTR_W-1:0] w_sp_e;
    logic             w_acc_e;
    logic [CNT_W-1:0] w_rem_e;
    logic [PTR_W-1:0] w_sp_inc;
    logic [CNT_W-1:0] w_rem_dec;
    logic             w_we;
    logic [CNT_W-1:0] w_done;
    logic [1:0]       w_kind;
    logic             w_imm_load;
    logic [CMP_W-1:0] w_min1;
    logic [CMP_W-1:0] w_min2;
    logic [ADDR_W-1:0] w_raddr;

    assign w_lvl   = r_wp - r_rp;
    assign w_space = PTR_W'(DEPTH) - w_lvl;

    // read clamp: min(count, level, MAX_READ)
    assign w_min1 = (CMP_W'(i_count) < CMP_W'(w_lvl)) ? CMP_W'(i_count) : CMP_W'(w_lvl);
    assign w_min2 = (w_min1 < CMP_W'(MAX_READ)) ? w_min1 : CMP_W'(MAX_READ);

    assign o_stat.out_free = !r_ovalid || i_ready;
    assign o_stat.rd_empty = r_hold || (i_count == '0) || (w_lvl == '0);
    assign o_stat.rd_n     = N_W'(w_min2);

    // burst staging
    assign w_acc_ok  = (i_count != '0) && (CMP_W'(i_count) <= CMP_W'(w_space));
    assign w_sp_e    = i_first ? r_wp : r_sp;
    assign w_acc_e   = i_first ? w_acc_ok : r_acc;
    assign w_rem_e   = i_first ? (w_acc_ok ? i_count : '0) : r_rem;
    assign w_sp_inc  = w_sp_e + PTR_W'(1);
    assign w_rem_dec = w_rem_e - CNT_W'(1);
    assign w_we      = i_cmd.op_write && w_acc_e && (w_rem_e != '0);

    always_comb begin
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_sp   = r_sp;
        n_rem  = r_rem;
        n_acc  = r_acc;
        n_base = r_base;
        w_done = '0;
        w_kind = KIND_WACK;
        if (i_cmd.op_write) begin
            w_kind = KIND_WACK;
            if (w_we) begin
                n_sp  = w_sp_inc;
                n_rem = w_rem_dec;
                n_acc = w_acc_e;
                if (w_rem_dec == '0) begin
                    w_done = CNT_W'(PTR_W'(w_sp_inc - r_wp));
                    n_wp   = w_sp_inc;
                    n_acc  = 1'b0;
                end
            end else begin
                n_sp  = w_sp_e;
                n_rem = w_rem_e;
                n_acc = w_acc_e;
            end
        end
        if (i_cmd.op_drain) begin
            w_kind = KIND_DRAIN;
            w_done = CNT_W'(w_lvl);
            n_rp   = r_wp;
        end
        if (i_cmd.op_empty) begin
            w_kind = KIND_EMPTY;
        end
        if (i_cmd.op_read) begin
            n_base = r_rp;
            n_rp   = r_rp + PTR_W'(o_stat.rd_n);
        end
    end

    assign w_lvl_next = n_wp - n_rp;
    assign w_imm_load = i_cmd.op_write || i_cmd.op_drain || i_cmd.op_empty;
    assign w_raddr    = ADDR_W'(r_base + PTR_W'(i_cmd.rd_off));
    assign n_ovalid   = (w_imm_load || i_cmd.rd_load) ? 1'b1 : (i_ready ? 1'b0 : r_ovalid);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_sp_e[ADDR_W-1:0]] <= i_data_in;
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_sp     <= '0;
            r_rem    <= '0;
            r_acc    <= 1'b0;
            r_base   <= '0;
            r_hold   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_sp     <= n_sp;
            r_rem    <= n_rem;
            r_acc    <= n_acc;
            r_base   <= n_base;
            r_ovalid <= n_ovalid;
            if (i_cfg_wen) begin
                r_hold <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_imm_load || i_cmd.rd_load) begin
            r_readable <= r_hold ? '0 : CNT_W'(w_lvl_next);
            r_writable <= CNT_W'(PTR_W'(PTR_W'(DEPTH) - w_lvl_next));
        end
        if (w_imm_load) begin
            r_kind <= w_kind;
            r_dout <= '0;
            r_done <= w_done;
            r_last <= 1'b1;
        end else if (i_cmd.rd_load) begin
            r_kind <= KIND_RDATA;
            r_dout <= r_rdata;
            r_done <= CNT_W'(i_cmd.rd_n);
            r_last <= i_cmd.rd_last;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_kind       = r_kind;
    assign o_data_out   = r_dout;
    assign o_done_count = r_done;
    assign o_last       = r_last;
    assign o_readable   = r_readable;
    assign o_writable   = r_writable;

endmodule

// ===== sv/byte_ring_fifo_block_commit.sv =====
// Channel     Dir  Content
// s_axis      in   tuser {first, cmd}; tdata {count, data_in}
// m_axis      out  tuser kind; tlast last;
//                  tdata {writable_space, readable_level, done_count, data_out}
// cfg         in   i_cfg_wen / i_cfg_wdata: hold_reads, written on the enable edge
//
// Write, drain, empty read and unused commands are handled on acceptance; a new word
// is taken whenever the output register is free or being emptied.
// A read of n bytes walks the byte store through its single registered read
// port, one byte per cycle unless the output stalls, and blocks input meanwhile.
// Output backpressure stalls the read walk; the pending byte is held.
// Reset (synchronous, active low) clears pointers, burst state, hold and
// output valid; the byte store needs no clearing pass.
module byte_ring_fifo_block_commit
    import brfbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_wdata,    // hold_reads
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] data_in, [20:8] count, zero pad
    input  logic [2:0]  s_axis_tuser,   // [1:0] cmd, [2] first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] data_out, [20:8] done_count,
                                        // [33:21] readable_level,
                                        // [46:34] writable_space, zero pad
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic [7:0]       w_data_out;
    logic [CNT_W-1:0] w_done;
    logic [CNT_W-1:0] w_readable;
    logic [CNT_W-1:0] w_writable;

    // sequencing: per-command dispatch and the read walk
    brfbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser[1:0]),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // pointers, staging, byte store and output register
    brfbc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_data_in    (s_axis_tdata[7:0]),
        .i_count      (s_axis_tdata[20:8]),
        .i_first      (s_axis_tuser[2]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_kind       (m_axis_tuser),
        .o_data_out   (w_data_out),
        .o_done_count (w_done),
        .o_last       (m_axis_tlast),
        .o_readable   (w_readable),
        .o_writable   (w_writable)
    );

    assign m_axis_tdata = {1'b0, w_writable, w_readable, w_done, w_data_out};

endmodule

// ===== sv/brfbc_checker.sv =====
`include "byte_ring_fifo_block_commit_defines.svh"

module brfbc_checker
    import brfbc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] i_m_tdata,
    input logic [1:0]  i_m_tuser,
    input logic        i_m_tlast
);

    logic [CNT_W:0] w_sum;
    logic           w_full_ok;
    logic           w_empty_ok;
    logic           w_imm_ok;

    assign w_sum      = {1'b0, i_m_tdata[33:21]} + {1'b0, i_m_tdata[46:34]};
    assign w_full_ok  = (i_m_tdata[33:21] == '0) || (w_sum == (CNT_W + 1)'(DEPTH));
    assign w_empty_ok = i_m_tlast && (i_m_tdata[20:8] == '0) && (i_m_tdata[7:0] == '0);
    assign w_imm_ok   = i_m_tlast && (i_m_tdata[7:0] == '0);

    `BRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid, "output word dropped under stall")
    `BRF_ASSERT_IMPL(a_level_sum, i_clk, i_rst_n, i_m_tvalid, w_full_ok, "readable plus writable differs from depth")
    `BRF_ASSERT_IMPL(a_empty_read, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser == KIND_EMPTY), w_empty_ok, "bad empty read word")
    `BRF_ASSERT_IMPL(a_single_word, i_clk, i_rst_n, i_m_tvalid && ((i_m_tuser == KIND_WACK) || (i_m_tuser == KIND_DRAIN)), w_imm_ok, "ack or drain word malformed")

endmodule

bind byte_ring_fifo_block_commit brfbc_checker u_brfbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);

// ===== test/tb_byte_ring_fifo_block_commit.sv =====
`timescale 1ns / 100ps

module tb_byte_ring_fifo_block_commit;
    import brfbc_pkg::*;

    // cmd 3 is not decoded by the block: no state change, no result
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // one input word as the sender sees it; pause_here is a marker that holds the
    // sender until every expected result is back, it never reaches the bus
    typedef struct {
        logic [1:0]       cmd;
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
        logic             first;
        bit               pause_here;
    } t_fifo_word;

    typedef struct {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [CNT_W-1:0] done;
        logic             last;
        logic [CNT_W-1:0] rlevel;
        logic [CNT_W-1:0] wspace;
    } t_fifo_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wen     = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // [7:0] data_in, [20:8] count, zero pad
    logic [2:0]  s_axis_tuser  = '0;    // [1:0] cmd, [2] first
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [7:0] data_out, [20:8] done_count,
                                        // [33:21] readable_level,
                                        // [46:34] writable_space, zero pad
    logic [1:0]  m_axis_tuser;          // [1:0] kind
    logic        m_axis_tlast;

    byte_ring_fifo_block_commit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow FIFO: own copy of store, pointers, open burst and hold bit
    // ------------------------------------------------------------------
    logic [7:0]       shadow_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] stage_ptr;
    logic [CNT_W-1:0] burst_left;
    logic             burst_open;
    logic             hold_q;

    t_fifo_word   word_backlog [$];     // words waiting for the sender
    t_fifo_result due_results  [$];     // results the block still owes

    int tx_idle_pct = 26;
    int rx_idle_pct = 77;
    int queued_words;
    int sent_words;
    int seen_results;
    int n_errors;
    int n_commits;
    int n_rejects;
    int bytes_read;
    int peak_level;
    int n_cfg_writes;

    function void owe_result(logic [1:0] kind, logic [7:0] data, logic [CNT_W-1:0] done,
                             logic last);
        t_fifo_result     r;
        logic [PTR_W-1:0] lvl;
        lvl      = wr_ptr - rd_ptr;
        r.kind   = kind;
        r.data   = data;
        r.done   = done;
        r.last   = last;
        r.rlevel = hold_q ? '0 : lvl;
        r.wspace = CNT_W'(DEPTH) - lvl;
        if (int'(lvl) > peak_level)
            peak_level = int'(lvl);
        due_results.push_back(r);
    endfunction

    // Advance the shadow FIFO by one accepted word and queue what it owes.
    function void fifo_apply(t_fifo_word w);
        logic [PTR_W-1:0] lvl;
        logic [PTR_W-1:0] space;
        logic [CNT_W-1:0] done;
        logic [CNT_W-1:0] n;
        logic [PTR_W-1:0] start;
        logic [PTR_W-1:0] p;
        lvl  = wr_ptr - rd_ptr;
        done = '0;
        case (w.cmd)
            CMD_WRITE: begin
                if (w.first) begin
                    // a new first byte always drops whatever burst was open
                    space      = CNT_W'(DEPTH) - lvl;
                    burst_open = 1'b0;
                    burst_left = '0;
                    stage_ptr  = wr_ptr;
                    if (w.count != 0 && w.count <= space) begin
                        burst_open = 1'b1;
                        burst_left = w.count;
                    end else begin
                        n_rejects++;
                    end
                end
                if (burst_open && burst_left != 0) begin
                    shadow_mem[stage_ptr[ADDR_W-1:0]] = w.data;
                    stage_ptr  = stage_ptr + 1'b1;
                    burst_left = burst_left - 1'b1;
                    if (burst_left == 0) begin
                        // commit: the whole burst becomes visible at once
                        done       = stage_ptr - wr_ptr;
                        wr_ptr     = stage_ptr;
                        burst_open = 1'b0;
                        n_commits++;
                    end
                end
                owe_result(KIND_WACK, 8'h00, done, 1'b1);
            end
            CMD_READ: begin
                if (hold_q || w.count == 0 || lvl == 0) begin
                    owe_result(KIND_EMPTY, 8'h00, '0, 1'b1);
                end else begin
                    n = w.count;
                    if (n > lvl)
                        n = lvl;
                    if (n > MAX_READ)
                        n = CNT_W'(MAX_READ);
                    start  = rd_ptr;
                    rd_ptr = rd_ptr + n;
                    for (int k = 0; k < int'(n); k++) begin
                        p = start + PTR_W'(k);
                        owe_result(KIND_RDATA, shadow_mem[p[ADDR_W-1:0]], n, k == int'(n) - 1);
                    end
                    bytes_read += int'(n);
                end
            end
            CMD_DRAIN: begin
                // only committed bytes go; an open burst keeps staging
                rd_ptr = wr_ptr;
                owe_result(KIND_DRAIN, 8'h00, lvl, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: one word per handshake, random gaps, pause markers honored
    // ------------------------------------------------------------------
    t_fifo_word cur_word;

    always @(posedge i_clk) begin
        logic go;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                fifo_apply(cur_word);
                sent_words++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                go = 1'b0;
                if (word_backlog.size() != 0 && word_backlog[0].pause_here &&
                    due_results.size() == 0)
                    word_backlog.delete(0);
                if (word_backlog.size() != 0 && !word_backlog[0].pause_here &&
                    $urandom_range(99) >= tx_idle_pct) begin
                    cur_word = word_backlog.pop_front();
                    go       = 1'b1;
                end
                s_axis_tvalid <= go;
                if (go) begin
                    s_axis_tdata <= {3'b000, cur_word.count, cur_word.data};
                    s_axis_tuser <= {cur_word.first, cur_word.cmd};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each word out against the oldest owed result
    // ------------------------------------------------------------------
    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= 40)
                $display("%0d ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_fifo_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_results++;
                if (due_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 40)
                        $display("%0d ns: unexpected word, expected none, got kind %0d data %0d",
                                 $time, m_axis_tuser, m_axis_tdata[7:0]);
                end else begin
                    want = due_results.pop_front();
                    check_field("kind",           want.kind,   m_axis_tuser);
                    check_field("data_out",       want.data,   m_axis_tdata[7:0]);
                    check_field("done_count",     want.done,   m_axis_tdata[20:8]);
                    check_field("last",           want.last,   m_axis_tlast);
                    check_field("readable_level", want.rlevel, m_axis_tdata[33:21]);
                    check_field("writable_space", want.wspace, m_axis_tdata[46:34]);
                    check_field("tdata pad",      1'b0,        m_axis_tdata[47]);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic put_word(logic [1:0] cmd, logic [7:0] data, logic [CNT_W-1:0] count,
                            logic first);
        t_fifo_word w;
        w.cmd        = cmd;
        w.data       = data;
        w.count      = count;
        w.first      = first;
        w.pause_here = 1'b0;
        word_backlog.push_back(w);
        if (cmd != CMD_UNUSED)
            queued_words++;
    endtask

    // continuation bytes; count carries junk since only the first byte's count matters
    task automatic put_follow(int nbytes);
        for (int i = 0; i < nbytes; i++)
            put_word(CMD_WRITE, 8'($urandom), CNT_W'($urandom), 1'b0);
    endtask

    task automatic put_burst(int announce, int nbytes);
        put_word(CMD_WRITE, 8'($urandom), CNT_W'(announce), 1'b1);
        put_follow(nbytes - 1);
    endtask

    task automatic put_read(int count);
        put_word(CMD_READ, 8'($urandom), CNT_W'(count), 1'($urandom));
    endtask

    task automatic put_drain();
        put_word(CMD_DRAIN, 8'($urandom), CNT_W'($urandom), 1'($urandom));
    endtask

    function automatic int pick_len();
        if ($urandom_range(9) < 7)
            return $urandom_range(1, 8);
        return $urandom_range(9, 24);
    endfunction

    // Mostly well-formed bursts and reads with random content, plus broken bursts,
    // stray bytes, drains, interleaving and undecoded commands.
    task automatic load_random(int target);
        t_fifo_word mark;
        int stop;
        int sel;
        int len;
        int r;
        int k;
        bit paused;
        stop   = queued_words + target;
        paused = 1'b0;
        while (queued_words < stop) begin
            if (!paused && queued_words >= stop - target / 2) begin
                mark.cmd        = CMD_UNUSED;
                mark.data       = '0;
                mark.count      = '0;
                mark.first      = 1'b0;
                mark.pause_here = 1'b1;
                word_backlog.push_back(mark);
                paused = 1'b1;
            end
            sel = $urandom_range(99);
            len = pick_len();
            if (len > stop - queued_words)
                len = stop - queued_words;                              // stay near target
            if (sel < 40) begin
                r = $urandom_range(9);
                if (r == 0)
                    put_burst(0, $urandom_range(1, 3));                 // zero length
                else if (r == 1)
                    put_burst($urandom_range(4096), $urandom_range(1, 3)); // huge, cut off
                else if (r == 2)
                    put_burst(len, $urandom_range(1, len));             // maybe short
                else
                    put_burst(len, len);
            end else if (sel < 75) begin
                r = $urandom_range(9);
                if (r < 7)
                    put_read($urandom_range(1, 70));
                else if (r == 7)
                    put_read(0);
                else
                    put_read($urandom_range(4096));
            end else if (sel < 82) begin
                put_drain();
            end else if (sel < 87) begin
                put_word(CMD_UNUSED, 8'($urandom), CNT_W'($urandom), 1'($urandom));
            end else if (sel < 92) begin
                put_follow(1);                                          // stray byte
            end else begin
                // read or drain landing inside an open burst
                len = (len < 2) ? 2 : len;
                k   = $urandom_range(1, len - 1);
                put_burst(len, k);
                if ($urandom_range(1))
                    put_read($urandom_range(1, 70));
                else
                    put_drain();
                put_follow(len - k);
            end
        end
    endtask

    // Wait until the sender is empty and nothing is owed, then let the block
    // finish any word that owes nothing.
    task automatic settle();
        do
            @(negedge i_clk);
        while (word_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0);
        repeat (MAX_READ + 6) @(negedge i_clk);
    endtask

    task automatic set_hold(logic v);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        hold_q = v;
        n_cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        wr_ptr     = '0;
        rd_ptr     = '0;
        stage_ptr  = '0;
        burst_left = '0;
        burst_open = 1'b0;
        hold_q     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles 26%, receiver 77%
        set_hold(1'b0);
        put_read(5);                                        // read on empty FIFO
        put_drain();                                        // drain on empty FIFO
        put_word(CMD_WRITE, 8'hFF, '0, 1'b1);               // zero-length burst
        put_word(CMD_WRITE, 8'h00, CNT_W'(4095), 1'b0);     // stray byte
        put_word(CMD_WRITE, 8'h00, CNT_W'(3), 1'b1);
        put_word(CMD_WRITE, 8'hFF, '0, 1'b0);
        put_word(CMD_WRITE, 8'hA5, CNT_W'(8191), 1'b0);     // commits 3
        put_read(0);                                        // zero-count read
        put_read(4096);                                     // clamped to level
        put_word(CMD_WRITE, 8'h11, CNT_W'(4096), 1'b1);     // full-depth burst opened
        put_word(CMD_WRITE, 8'h22, '0, 1'b0);
        put_word(CMD_WRITE, 8'h5A, CNT_W'(2), 1'b1);        // restart drops staged bytes
        put_word(CMD_WRITE, 8'h3C, '0, 1'b0);
        put_read(1);
        put_burst(4, 2);
        put_drain();                                        // drain inside open burst
        put_follow(2);                                      // burst still commits
        put_word(CMD_UNUSED, 8'hFF, CNT_W'(8191), 1'b1);
        put_word(CMD_WRITE, 8'h77, CNT_W'(4096), 1'b1);     // above free space
        put_follow(1);                                      // ignored tail
        put_read(64);
        settle();

        // hold set: reads come back empty and level reads zero
        set_hold(1'b1);
        put_burst(2, 2);
        put_read(2);
        put_read(0);
        put_drain();
        put_burst(1, 1);
        put_read(1);
        settle();

        set_hold(1'b0);
        load_random(8);
        settle();
        set_hold(1'b1);
        load_random(4);
        settle();

        // sender idles 77%, receiver 26%
        set_hold(1'b0);
        tx_idle_pct = 77;
        rx_idle_pct = 26;
        load_random(8);
        settle();

        // no idling: one long burst so a read hits the per-request cap
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        put_burst(65, 65);
        put_read(70);                                       // capped at MAX_READ
        put_drain();
        settle();

        $display("Sent %0d words, checked %0d results: %0d bursts committed, %0d rejected,",
                 sent_words, seen_results, n_commits, n_rejects);
        $display("%0d bytes read back, peak level %0d, %0d hold writes, read cap reached.",
                 bytes_read, peak_level, n_cfg_writes);
        if (n_errors == 0)
            $display("tb_byte_ring_fifo_block_commit passed");
        else
            $display("tb_byte_ring_fifo_block_commit failed");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #5ms;
        $display("%0d ns: timeout, %0d results still owed", $time, due_results.size());
        $display("tb_byte_ring_fifo_block_commit failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/brfbc_pkg.sv
sv/brfbc_ctrl.sv
sv/brfbc_dp.sv
sv/byte_ring_fifo_block_commit.sv
sv/brfbc_checker.sv
test/tb_byte_ring_fifo_block_commit.sv
